// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only out of reset
`define CHS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// property checked at every edge, reset included
`define CHS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: label");

`endif

// ===== src/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Types, codes and constants of the CHS / LBA address translator.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

  localparam int NUM_DRIVES   = 4;
  localparam int ADDRESS_BITS = 48;

  localparam int LBA_W      = 48;
  localparam int GEOM_W     = 63;
  localparam int HEADS_W    = 8;
  localparam int SPT_W      = 6;
  localparam int PROD_W     = 25;
  localparam int MUL_W      = PROD_W + SPT_W;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = LBA_W / DIV_STEPS;
  localparam int PIPE_DIV   = 2 * DIV_STAGES;

  localparam logic [LBA_W-1:0] ADDR_MASK =
    LBA_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  // geometry word layout
  localparam int GEOM_TOTAL_LSB   = 0;
  localparam int GEOM_HEADS_LSB   = 48;
  localparam int GEOM_SPT_LSB     = 56;
  localparam int GEOM_PRESENT_BIT = 62;

  // operations
  localparam logic [1:0] OP_CHS_TO_LBA = 2'd0;
  localparam logic [1:0] OP_LBA_TO_CHS = 2'd1;
  localparam logic [1:0] OP_CHECK      = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // divisor select of a divider stage
  localparam logic DIV_SEL_SPT   = 1'b0;
  localparam logic DIV_SEL_HEADS = 1'b1;

  typedef logic [NUM_DRIVES-1:0][GEOM_W-1:0] geom_arr_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         status;
    logic [HEADS_W-1:0] heads;
    logic [SPT_W-1:0]   spt;
    logic [SPT_W-1:0]   sec_in;
    logic [PROD_W-1:0]  prod;
    logic [LBA_W-1:0]   acc;
    logic [HEADS_W-1:0] rem;
    logic [SPT_W-1:0]   sec_res;
  } item_t;

endpackage

`default_nettype wire

// ===== src/chs_geom_regs.sv =====
// ----------------------------------------------------------------------------
// chs_geom_regs
// Per-drive geometry registers written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_geom_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [chs_pkg::GEOM_W-1:0]  cfg_data,
  output chs_pkg::geom_arr_t               geom
);

  chs_pkg::geom_arr_t geom_r;

  assign cfg_ready = 1'b1;
  assign geom      = geom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= '0;
    end else if (cfg_valid && (int'(cfg_index) < chs_pkg::NUM_DRIVES)) begin
      geom_r[cfg_index] <= cfg_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/chs_front.sv =====
// ----------------------------------------------------------------------------
// chs_front
// Entry stage: geometry select, status decode, range check, c*heads+h.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_op,
  input  wire logic [1:0]                 in_drive,
  input  wire logic [chs_pkg::LBA_W-1:0]  in_block_address,
  input  wire logic [15:0]                in_cylinder_in,
  input  wire logic [7:0]                 in_head_in,
  input  wire logic [5:0]                 in_sector_in,
  input  wire logic [16:0]                in_transfer_count,
  input  wire chs_pkg::geom_arr_t         geom,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output chs_pkg::item_t                  out_data
);

  logic                          valid_r;
  chs_pkg::item_t                data_r;
  chs_pkg::item_t                data_nxt;
  logic [chs_pkg::GEOM_W-1:0]    g;
  logic [chs_pkg::LBA_W-1:0]     total;
  logic [chs_pkg::LBA_W-1:0]     lba;
  logic [chs_pkg::HEADS_W-1:0]   heads;
  logic [chs_pkg::SPT_W-1:0]     spt;
  logic                          present;
  logic                          range_bad;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    g = '0;
    if (int'(in_drive) < chs_pkg::NUM_DRIVES) begin
      g = geom[in_drive];
    end
    total   = g[chs_pkg::GEOM_TOTAL_LSB +: chs_pkg::LBA_W];
    heads   = g[chs_pkg::GEOM_HEADS_LSB +: chs_pkg::HEADS_W];
    spt     = g[chs_pkg::GEOM_SPT_LSB +: chs_pkg::SPT_W];
    present = g[chs_pkg::GEOM_PRESENT_BIT];
    lba     = in_block_address & chs_pkg::ADDR_MASK;

    range_bad = (in_transfer_count == '0) || (lba >= total) ||
                (({1'b0, lba} + (chs_pkg::LBA_W + 1)'(in_transfer_count)) >
                 {1'b0, total});

    data_nxt         = '0;
    data_nxt.op      = in_op;
    data_nxt.heads   = heads;
    data_nxt.spt     = spt;
    data_nxt.sec_in  = in_sector_in;
    data_nxt.prod    = chs_pkg::PROD_W'(in_cylinder_in) * chs_pkg::PROD_W'(heads) +
                       chs_pkg::PROD_W'(in_head_in);
    data_nxt.acc     = lba;
    data_nxt.status  = chs_pkg::ST_OK;

    unique case (in_op)
      chs_pkg::OP_CHS_TO_LBA: begin
        data_nxt.status = present ? chs_pkg::ST_OK : chs_pkg::ST_ABSENT;
      end
      chs_pkg::OP_LBA_TO_CHS: begin
        if (!present) begin
          data_nxt.status = chs_pkg::ST_ABSENT;
        end else if ((heads == '0) || (spt == '0)) begin
          data_nxt.status = chs_pkg::ST_INVALID;
        end
      end
      chs_pkg::OP_CHECK: begin
        if (!present) begin
          data_nxt.status = chs_pkg::ST_ABSENT;
        end else if (range_bad) begin
          data_nxt.status = chs_pkg::ST_INVALID;
        end
      end
      default: begin
        data_nxt.status = chs_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/chs_div_stage.sv =====
// ----------------------------------------------------------------------------
// chs_div_stage
// One pipeline stage of a restoring divider: DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_div_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            div_sel,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire chs_pkg::item_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output chs_pkg::item_t       out_data
);

  logic                          valid_r;
  chs_pkg::item_t                data_r;
  chs_pkg::item_t                data_nxt;
  logic [chs_pkg::HEADS_W-1:0]   divisor;
  logic [chs_pkg::HEADS_W:0]     part;
  logic [chs_pkg::LBA_W-1:0]     acc;
  logic [chs_pkg::HEADS_W-1:0]   rem;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    divisor = (div_sel == chs_pkg::DIV_SEL_HEADS) ? in_data.heads :
              chs_pkg::HEADS_W'(in_data.spt);
    acc  = in_data.acc;
    rem  = in_data.rem;
    part = '0;
    for (int k = 0; k < chs_pkg::DIV_STEPS; k++) begin
      part = {rem, acc[chs_pkg::LBA_W-1]};
      acc  = {acc[chs_pkg::LBA_W-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
        part   = part - {1'b0, divisor};
        acc[0] = 1'b1;
      end
      rem = part[chs_pkg::HEADS_W-1:0];
    end
    data_nxt     = in_data;
    data_nxt.acc = acc;
    data_nxt.rem = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/chs_out_stage.sv =====
// ----------------------------------------------------------------------------
// chs_out_stage
// Result register: finishes the CHS-to-address sum and formats the word.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_out_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire chs_pkg::item_t             in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [chs_pkg::LBA_W-1:0]       out_address_out,
  output logic [31:0]                     out_cylinder_out,
  output logic [7:0]                      out_head_out,
  output logic [5:0]                      out_sector_out
);

  logic                         valid_r;
  logic [1:0]                   status_r;
  logic [chs_pkg::LBA_W-1:0]    address_r;
  logic [31:0]                  cylinder_r;
  logic [7:0]                   head_r;
  logic [5:0]                   sector_r;
  logic [chs_pkg::LBA_W-1:0]    address_nxt;
  logic [31:0]                  cylinder_nxt;
  logic [7:0]                   head_nxt;
  logic [5:0]                   sector_nxt;
  logic [chs_pkg::MUL_W-1:0]    mul;
  logic                         ok;

  assign in_ready         = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_address_out  = address_r;
  assign out_cylinder_out = cylinder_r;
  assign out_head_out     = head_r;
  assign out_sector_out   = sector_r;

  always_comb begin
    ok  = (in_data.status == chs_pkg::ST_OK);
    mul = chs_pkg::MUL_W'(in_data.prod) * chs_pkg::MUL_W'(in_data.spt);
    address_nxt  = '0;
    cylinder_nxt = '0;
    head_nxt     = '0;
    sector_nxt   = '0;
    case (in_data.op)
      chs_pkg::OP_CHS_TO_LBA: begin
        if (ok) begin
          address_nxt = (chs_pkg::LBA_W'(mul) + chs_pkg::LBA_W'(in_data.sec_in) -
                         chs_pkg::LBA_W'(1)) & chs_pkg::ADDR_MASK;
        end
      end
      chs_pkg::OP_LBA_TO_CHS: begin
        if (ok) begin
          cylinder_nxt = in_data.acc[31:0];
          head_nxt     = in_data.rem;
          sector_nxt   = in_data.sec_res;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      status_r   <= in_data.status;
      address_r  <= address_nxt;
      cylinder_r <= cylinder_nxt;
      head_r     <= head_nxt;
      sector_r   <= sector_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/chs_lba_address_translator.sv =====
// ----------------------------------------------------------------------------
// chs_lba_address_translator
// Pipeline: entry stage, twelve divider stages of 8 quotient bits each,
// result register.
// Throughput: one word per cycle unless the output stalls; every stage holds under backpressure.
// Reset (synchronous, rst_n low) clears all stage valid bits and the
// geometry registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_lba_address_translator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [62:0]                cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_op,
  input  wire logic [1:0]                 in_drive,
  input  wire logic [47:0]                in_block_address,
  input  wire logic [15:0]                in_cylinder_in,
  input  wire logic [7:0]                 in_head_in,
  input  wire logic [5:0]                 in_sector_in,
  input  wire logic [16:0]                in_transfer_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [47:0]                     out_address_out,
  output logic [31:0]                     out_cylinder_out,
  output logic [7:0]                      out_head_out,
  output logic [5:0]                      out_sector_out
);

  chs_pkg::geom_arr_t geom;
  chs_pkg::item_t     pipe_data  [0:chs_pkg::PIPE_DIV];
  logic               pipe_valid [0:chs_pkg::PIPE_DIV];
  logic               pipe_ready [0:chs_pkg::PIPE_DIV];
  chs_pkg::item_t     mid_data;

  chs_geom_regs u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  chs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_drive          (in_drive),
    .in_block_address  (in_block_address),
    .in_cylinder_in    (in_cylinder_in),
    .in_head_in        (in_head_in),
    .in_sector_in      (in_sector_in),
    .in_transfer_count (in_transfer_count),
    .geom              (geom),
    .out_valid         (pipe_valid[0]),
    .out_ready         (pipe_ready[0]),
    .out_data          (pipe_data[0])
  );

  // between the two divisions: lba % spt plus one becomes the sector, remainder restarts
  always_comb begin
    mid_data         = pipe_data[chs_pkg::DIV_STAGES];
    mid_data.sec_res = chs_pkg::SPT_W'(pipe_data[chs_pkg::DIV_STAGES].rem) +
                       chs_pkg::SPT_W'(1);
    mid_data.rem     = '0;
  end

  for (genvar j = 0; j < chs_pkg::PIPE_DIV; j++) begin : g_div
    chs_pkg::item_t stage_in;
    if (j == chs_pkg::DIV_STAGES) begin : g_mid
      assign stage_in = mid_data;
    end else begin : g_plain
      assign stage_in = pipe_data[j];
    end

    chs_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .div_sel   ((j < chs_pkg::DIV_STAGES) ? chs_pkg::DIV_SEL_SPT :
                                              chs_pkg::DIV_SEL_HEADS),
      .in_valid  (pipe_valid[j]),
      .in_ready  (pipe_ready[j]),
      .in_data   (stage_in),
      .out_valid (pipe_valid[j+1]),
      .out_ready (pipe_ready[j+1]),
      .out_data  (pipe_data[j+1])
    );
  end

  chs_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (pipe_valid[chs_pkg::PIPE_DIV]),
    .in_ready         (pipe_ready[chs_pkg::PIPE_DIV]),
    .in_data          (pipe_data[chs_pkg::PIPE_DIV]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_address_out  (out_address_out),
    .out_cylinder_out (out_cylinder_out),
    .out_head_out     (out_head_out),
    .out_sector_out   (out_sector_out)
  );

endmodule

`default_nettype wire

// ===== src/chs_checker.sv =====
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the address translator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module chs_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_status,
  input  wire logic [47:0] out_address_out,
  input  wire logic [31:0] out_cylinder_out,
  input  wire logic [7:0]  out_head_out,
  input  wire logic [5:0]  out_sector_out
);

  logic [95:0] out_word;
  logic        status_legal;
  logic        fields_zero;

  assign out_word     = {out_status, out_address_out, out_cylinder_out, out_head_out,
                         out_sector_out};
  assign status_legal = (out_status == chs_pkg::ST_OK) ||
                        (out_status == chs_pkg::ST_ABSENT) ||
                        (out_status == chs_pkg::ST_INVALID);
  assign fields_zero  = (out_address_out == '0) && (out_cylinder_out == '0) &&
                        (out_head_out == '0) && (out_sector_out == '0);

  `CHS_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid)

  `CHS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word))

  `CHS_ASSERT(a_status_legal, clk, rst_n, out_valid |-> status_legal)

  `CHS_ASSERT(a_error_zero, clk, rst_n, out_valid && out_status != chs_pkg::ST_OK |-> fields_zero)

endmodule

bind chs_lba_address_translator chs_checker u_chs_checker (.*);

`default_nettype wire

// ===== tb/tb_chs_lba_address_translator.sv =====
// ----------------------------------------------------------------------------
// tb_chs_lba_address_translator
// Drives translation requests into the CHS / block address translator and
// checks every result word against an in-bench prediction of the three
// operations, across several drive geometry settings, random idle gaps on
// both channels and one long output stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_chs_lba_address_translator;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  drive;
    logic [47:0] lba;
    logic [15:0] cyl;
    logic [7:0]  head;
    logic [5:0]  sec;
    logic [16:0] count;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] address;
    logic [31:0] cylinder;
    logic [7:0]  head;
    logic [5:0]  sector;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [62:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [1:0]  in_drive;
  logic [47:0] in_block_address;
  logic [15:0] in_cylinder_in;
  logic [7:0]  in_head_in;
  logic [5:0]  in_sector_in;
  logic [16:0] in_transfer_count;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [47:0] out_address_out;
  logic [31:0] out_cylinder_out;
  logic [7:0]  out_head_out;
  logic [5:0]  out_sector_out;

  chs_pkg::geom_arr_t geom_model;
  result_t   translations_due[$];
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;
  int        rx_hold_cycles = 0;
  int        mismatches = 0;
  int        n_requests = 0;
  int        n_checked = 0;
  int        n_geometry_writes = 0;

  chs_lba_address_translator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_drive          (in_drive),
    .in_block_address  (in_block_address),
    .in_cylinder_in    (in_cylinder_in),
    .in_head_in        (in_head_in),
    .in_sector_in      (in_sector_in),
    .in_transfer_count (in_transfer_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_address_out   (out_address_out),
    .out_cylinder_out  (out_cylinder_out),
    .out_head_out      (out_head_out),
    .out_sector_out    (out_sector_out)
  );

  always #1 clk = ~clk;

  function automatic result_t translate(request_t r);
    result_t     res;
    logic [62:0] g;
    logic [63:0] total, heads, spt, lba, sum;
    res   = '0;
    g     = geom_model[r.drive];
    total = 64'(g[47:0]);
    heads = 64'(g[55:48]);
    spt   = 64'(g[61:56]);
    lba   = 64'(r.lba & chs_pkg::ADDR_MASK);
    if (r.op == OP_UNDEFINED) begin
      res.status = chs_pkg::ST_INVALID;
    end else if (!g[chs_pkg::GEOM_PRESENT_BIT]) begin
      res.status = chs_pkg::ST_ABSENT;
    end else if (r.op == chs_pkg::OP_CHS_TO_LBA) begin
      // a zero sector wraps through s-1
      sum = (64'(r.cyl) * heads + 64'(r.head)) * spt + 64'(r.sec) - 64'd1;
      res.address = sum[47:0] & chs_pkg::ADDR_MASK;
    end else if (r.op == chs_pkg::OP_LBA_TO_CHS) begin
      if (heads == 0 || spt == 0) begin
        res.status = chs_pkg::ST_INVALID;
      end else begin
        res.sector   = 6'((lba % spt) + 64'd1);
        res.head     = 8'((lba / spt) % heads);
        res.cylinder = 32'(lba / (heads * spt));
      end
    end else if (r.count == 0 || lba >= total || lba + 64'(r.count) > total) begin
      res.status = chs_pkg::ST_INVALID;
    end
    return res;
  endfunction

  function automatic request_t make_req(logic [1:0] op, logic [1:0] drive,
                                        logic [47:0] lba, logic [15:0] cyl,
                                        logic [7:0] head, logic [5:0] sec,
                                        logic [16:0] count);
    request_t r;
    r = '{op: op, drive: drive, lba: lba, cyl: cyl, head: head, sec: sec,
          count: count};
    return r;
  endfunction

  function automatic logic [62:0] pack_geom(logic present, logic [5:0] spt,
                                            logic [7:0] heads, logic [47:0] total);
    return {present, spt, heads, total};
  endfunction

  function automatic logic [47:0] random_lba();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0] >> $urandom_range(0, 47);
  endfunction

  function automatic logic [62:0] random_geometry();
    logic [7:0] heads;
    logic [5:0] spt;
    case ($urandom_range(0, 7))
      0:       heads = '0;
      1:       heads = '1;
      default: heads = 8'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 7))
      0:       spt = '0;
      1:       spt = '1;
      default: spt = 6'($urandom_range(1, 63));
    endcase
    return pack_geom($urandom_range(0, 7) != 0, spt, heads, random_lba());
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    logic [47:0] total;
    pick    = $urandom_range(0, 15);
    r.op    = (pick == 0) ? OP_UNDEFINED : 2'(pick % 3);
    r.drive = 2'($urandom_range(0, 3));
    r.lba   = random_lba();
    r.cyl   = 16'($urandom);
    r.head  = 8'($urandom);
    r.sec   = 6'($urandom);
    case ($urandom_range(0, 7))
      0:       r.count = 17'd65536;
      1:       r.count = '0;
      default: r.count = 17'($urandom_range(1, 65535));
    endcase
    // aim most range checks at the end of the drive
    total = geom_model[r.drive][47:0];
    if (r.op == chs_pkg::OP_CHECK && $urandom_range(0, 3) != 0) begin
      r.lba   = total - 48'($urandom_range(0, 80));
      r.count = 17'($urandom_range(1, 80));
    end
    return r;
  endfunction

  // valid stays high across back-to-back words; this task lowers it only for a gap
  task automatic send_request(input request_t r);
    int gap;
    bit took;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= r.op;
    in_drive          <= r.drive;
    in_block_address  <= r.lba;
    in_cylinder_in    <= r.cyl;
    in_head_in        <= r.head;
    in_sector_in      <= r.sec;
    in_transfer_count <= r.count;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    translations_due.push_back(translate(r));
    n_requests++;
  endtask

  // every request yields a result word, so an empty queue means an empty pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (translations_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_geometry(input chs_pkg::geom_arr_t g);
    bit took;
    for (int i = 0; i < chs_pkg::NUM_DRIVES; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= g[i];
      do begin
        @(negedge clk);
        took = cfg_ready;
        @(posedge clk);
      end while (!took);
      geom_model[i] = g[i];
      n_geometry_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_absent_drives();
    send_request(make_req(chs_pkg::OP_CHS_TO_LBA, 2'd0, '0, '1, '1, '1, '1));
    send_request(make_req(chs_pkg::OP_LBA_TO_CHS, 2'd1, '1, '0, '0, '0, '0));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd2, 48'd5, 16'd1, 8'd1, 6'd1, 17'd1));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd3, '0, '0, '0, '0, 17'd65536));
    send_request(make_req(OP_UNDEFINED, 2'd3, '1, '1, '1, '1, '1));
  endtask

  task automatic test_chs_to_block();
    chs_pkg::geom_arr_t g;
    g[0] = pack_geom(1'b1, '1, '1, '1);
    g[1] = pack_geom(1'b1, 6'd1, 8'd1, 48'd1000);
    g[2] = pack_geom(1'b1, 6'd63, 8'd0, 48'd5000);
    g[3] = pack_geom(1'b1, 6'd0, 8'd16, 48'd100);
    wait_idle();
    set_geometry(g);
    send_request(make_req(chs_pkg::OP_CHS_TO_LBA, 2'd0, '0, '1, '1, 6'd63, '0));
    send_request(make_req(chs_pkg::OP_CHS_TO_LBA, 2'd0, '0, '0, '0, 6'd1, '0));
    send_request(make_req(chs_pkg::OP_CHS_TO_LBA, 2'd0, '0, '0, '0, 6'd0, '0));
    send_request(make_req(chs_pkg::OP_CHS_TO_LBA, 2'd3, '0, 16'd5, 8'd3, 6'd0, '0));
    send_request(make_req(chs_pkg::OP_CHS_TO_LBA, 2'd3, '0, 16'd5, 8'd3, 6'd10, '0));
    send_request(make_req(chs_pkg::OP_CHS_TO_LBA, 2'd1, '0, 16'd1234, 8'd7, 6'd1, '0));
  endtask

  task automatic test_block_to_chs();
    send_request(make_req(chs_pkg::OP_LBA_TO_CHS, 2'd0, '0, '0, '0, '0, '0));
    send_request(make_req(chs_pkg::OP_LBA_TO_CHS, 2'd0, '1, '0, '0, '0, '0));
    send_request(make_req(chs_pkg::OP_LBA_TO_CHS, 2'd0, 48'd16064, '0, '0, '0, '0));
    send_request(make_req(chs_pkg::OP_LBA_TO_CHS, 2'd1, '1, '0, '0, '0, '0));
    send_request(make_req(chs_pkg::OP_LBA_TO_CHS, 2'd2, 48'd77, '0, '0, '0, '0));
    send_request(make_req(chs_pkg::OP_LBA_TO_CHS, 2'd3, 48'd77, '0, '0, '0, '0));
  endtask

  task automatic test_transfer_check();
    send_request(make_req(chs_pkg::OP_CHECK, 2'd1, 48'd0, '0, '0, '0, 17'd0));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd1, 48'd999, '0, '0, '0, 17'd1));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd1, 48'd1000, '0, '0, '0, 17'd1));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd1, 48'd990, '0, '0, '0, 17'd11));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd0, 48'd0, '0, '0, '0, 17'd65536));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd0, 48'hFFFF_FFFF_FFFE, '0, '0, '0, 17'd1));
    send_request(make_req(chs_pkg::OP_CHECK, 2'd0, '1, '0, '0, '0, 17'd1));
    send_request(make_req(OP_UNDEFINED, 2'd0, '0, '0, '0, 6'd1, 17'd1));
  endtask

  task automatic test_backpressure();
    chs_pkg::geom_arr_t g;
    for (int d = 0; d < chs_pkg::NUM_DRIVES; d++) g[d] = random_geometry();
    wait_idle();
    set_geometry(g);
    tx_idle        = 1'b0;
    rx_hold_cycles = 100;
    repeat (48) send_request(random_request());
    tx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    chs_pkg::geom_arr_t g;
    for (int phase = 0; phase < 6; phase++) begin
      for (int d = 0; d < chs_pkg::NUM_DRIVES; d++)
        g[d] = (phase == 0) ? ((d == chs_pkg::NUM_DRIVES - 1) ? '0 : '1) :
                              random_geometry();
      wait_idle();
      set_geometry(g);
      tx_idle = (phase != 1 && phase != 5);
      rx_idle = (phase != 2 && phase != 5);
      repeat (60) send_request(random_request());
    end
  endtask

  initial begin : receiver
    int stall;
    bit took;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 6) : 0;
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  // a word seen with valid and ready at the falling edge moves at the next rise
  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (translations_due.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches++;
      end else begin
        want = translations_due.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_address_out !== want.address) begin
          $error("address_out: expected %h, actual %h", want.address, out_address_out);
          mismatches++;
        end
        if (out_cylinder_out !== want.cylinder) begin
          $error("cylinder_out: expected %h, actual %h", want.cylinder, out_cylinder_out);
          mismatches++;
        end
        if (out_head_out !== want.head) begin
          $error("head_out: expected %0d, actual %0d", want.head, out_head_out);
          mismatches++;
        end
        if (out_sector_out !== want.sector) begin
          $error("sector_out: expected %0d, actual %0d", want.sector, out_sector_out);
          mismatches++;
        end
        n_checked++;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_op             = '0;
    in_drive          = '0;
    in_block_address  = '0;
    in_cylinder_in    = '0;
    in_head_in        = '0;
    in_sector_in      = '0;
    in_transfer_count = '0;
    geom_model        = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_absent_drives();
    test_chs_to_block();
    test_block_to_chs();
    test_transfer_check();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (30) @(posedge clk);
    $display("summary: %0d requests, %0d result words checked, %0d geometry writes",
             n_requests, n_checked, n_geometry_writes);
    $display("covered: all operations, absent drives, zero geometry, overruns, stalls");
    if (mismatches == 0 && translations_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
